>>> rtl/core/crs_pkg.sv
package crs_pkg;

	localparam int MAX_KEYS_DEF = 64;
	localparam int MAX_DIM_DEF  = 4;

	// Wide enough for any slot or key count up to the largest table.
	localparam int IDX_W = 11;

	localparam int KEY_TIME_W = 16;
	localparam int COMP_W     = 32;
	localparam int QUERY_W    = 17;
	localparam int KCNT_W     = 7;
	localparam int VDIM_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int S_DATA_W   = 168;
	localparam int M_DATA_W   = 128;

	localparam int DIVIDEND_W = 31;
	localparam int DIVISOR_W  = 16;
	localparam int DIV_CNT_W  = 5;

	localparam logic [KEY_TIME_W-1:0] T_ONE = 16'd32768;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_DIM = 2'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// Cubic basis rows, one row per neighbouring key.
	localparam logic signed [3:0] BASIS [16] = '{
		-4'sd1,  4'sd2, -4'sd1,  4'sd0,
		 4'sd3, -4'sd5,  4'sd0,  4'sd2,
		-4'sd3,  4'sd4,  4'sd1,  4'sd0,
		 4'sd1, -4'sd1,  4'sd0,  4'sd0
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_A,
		ST_SRCH_C,
		ST_RD_PREV,
		ST_RD_CUR,
		ST_FRAC,
		ST_DIV,
		ST_H2,
		ST_H3,
		ST_HSAVE,
		ST_WGT,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

endpackage

>>> rtl/core/crs_div.sv
module crs_div
	import crs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic [DIVISOR_W:0]   rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVISOR_W:0]   trial;
	logic                 fits;

	// Restoring division: one quotient bit per cycle, dividend shifts out as quotient shifts in.
	assign trial = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/catmull_rom_spline_eval.sv
// Channel  Direction  Handshake                    Payload
// s        in         s_tvalid / s_tready          s_tdata, s_tuser (opcode)
// m        out        m_tvalid / m_tready          m_tdata (four components)
// cfg      in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// An evaluate transaction runs a linear search over the keys up to key k,
// where the search stops (at most key_count - 1), waits on the bit-serial
// divider (skipped when the fraction is zero), and weights each component
// on the shared 33x32 multiplier. Reset clears the sequencer, the
// configuration registers and the output valid; key memories are not
// cleared. A waiting result does not block a new transaction, but holds the
// next evaluation in its last step until taken.
module catmull_rom_spline_eval
	import crs_pkg::*;
#(
	parameter int MAX_KEYS = MAX_KEYS_DEF,
	parameter int MAX_DIM  = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// key_index, key_time, key_comp0..key_comp3, query_time, zero pad
	input  logic [S_DATA_W-1:0]   s_tdata,
	// opcode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_comp0, out_comp1, out_comp2, out_comp3
	output logic [M_DATA_W-1:0]   m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int JW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ACC_W = 66;

	state_t state_q, state_d;

	logic [KCNT_W-1:0] key_count_q;
	logic [VDIM_W-1:0] vector_dim_q;

	logic [KEY_TIME_W-1:0]        times_mem [MAX_KEYS];
	logic [MAX_DIM*COMP_W-1:0]    vec_mem   [MAX_KEYS];
	logic [KEY_TIME_W-1:0]        t_rd_q;
	logic [MAX_DIM*COMP_W-1:0]    v_rd_q;
	logic [KW-1:0]                t_addr;
	logic [KW-1:0]                v_addr;

	logic [KEY_TIME_W-1:0] t_q, tprev_q;
	logic [KW-1:0]         i_q, k_q;
	logic [1:0]            wi_q;
	logic [JW-1:0]         j_q;
	logic [KEY_TIME_W-1:0] h_q;
	logic [30:0]           h2_q;
	logic [45:0]           h3_q;
	logic signed [32:0]    w_q;
	logic signed [64:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q [MAX_DIM];
	logic                  m_tvalid_q;
	logic [M_DATA_W-1:0]   m_tdata_q;

	logic                  s_acc, cfg_acc;
	logic [IDX_W-1:0]      slot_ext, kc_ext;
	logic [CW-1:0]         cnt_c;
	logic [KW-1:0]         cnt_m1;
	logic [VDIM_W-1:0]     dim_c;
	logic signed [QUERY_W-1:0] qt;
	logic [KEY_TIME_W-1:0] t_clamp;
	logic [KW-1:0]         k_pick;
	logic signed [KW+1:0]  kn_s;
	logic [KW-1:0]         kn;
	logic signed [QUERY_W-1:0] num, den;
	logic                  h_zero;
	logic [DIVISOR_W-1:0]  an, ad;
	logic                  div_start;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] quo;
	logic signed [3:0]     c0, c1, c2, c3;
	logic signed [51:0]    poly;
	logic signed [51:0]    w_full;
	logic signed [32:0]    mul_a;
	logic signed [31:0]    mul_b;
	logic [M_DATA_W-1:0]   out_c;

	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= KCNT_W'(2);
			vector_dim_q <= VDIM_W'(3);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_KEY_COUNT:  key_count_q  <= cfg_data;
				REG_VECTOR_DIM: vector_dim_q <= cfg_data[VDIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign kc_ext = IDX_W'(key_count_q);
	always_comb begin
		if (kc_ext < IDX_W'(2))
			cnt_c = CW'(2);
		else if (kc_ext > IDX_W'(MAX_KEYS))
			cnt_c = CW'(MAX_KEYS);
		else
			cnt_c = kc_ext[CW-1:0];
		if (vector_dim_q == '0)
			dim_c = VDIM_W'(1);
		else if (vector_dim_q > VDIM_W'(MAX_DIM))
			dim_c = VDIM_W'(MAX_DIM);
		else
			dim_c = vector_dim_q;
	end
	assign cnt_m1 = KW'(cnt_c - CW'(1));

	// Input field decode.
	assign slot_ext = IDX_W'(s_tdata[5:0]);
	assign qt       = $signed(s_tdata[166:150]);
	always_comb begin
		if (qt < 0)
			t_clamp = '0;
		else if (qt > $signed({1'b0, T_ONE}))
			t_clamp = T_ONE;
		else
			t_clamp = qt[KEY_TIME_W-1:0];
	end

	// Key memories.
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == OP_LOAD && slot_ext < IDX_W'(MAX_KEYS)) begin
			times_mem[slot_ext[KW-1:0]] <= s_tdata[21:6];
			vec_mem[slot_ext[KW-1:0]]   <= s_tdata[22 +: MAX_DIM*COMP_W];
		end
		t_rd_q <= times_mem[t_addr];
		v_rd_q <= vec_mem[v_addr];
	end

	// Search result and neighbour index.
	always_comb begin
		k_pick = (t_rd_q >= t_q) ? i_q : cnt_m1;
		if (k_pick == '0)
			k_pick = KW'(1);
		kn_s = $signed({2'b00, k_q}) + $signed({{KW{1'b0}}, wi_q}) - (KW+2)'(2);
		if (kn_s < 0)
			kn = '0;
		else if (kn_s > $signed({2'b00, cnt_m1}))
			kn = cnt_m1;
		else
			kn = kn_s[KW-1:0];
	end

	// Local fraction operands.
	assign num = $signed({1'b0, t_q}) - $signed({1'b0, tprev_q});
	assign den = $signed({1'b0, t_rd_q}) - $signed({1'b0, tprev_q});
	assign h_zero = (den == 0) || (num == 0) || ((num < 0) != (den < 0));
	assign an = num[QUERY_W-1] ? DIVISOR_W'(-num) : num[DIVISOR_W-1:0];
	assign ad = den[QUERY_W-1] ? DIVISOR_W'(-den) : den[DIVISOR_W-1:0];

	crs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({an, 15'b0}),
		.divisor  (ad),
		.done     (div_done),
		.quotient (quo)
	);

	// Basis weight in Q46, rounded to Q30.
	assign c0 = BASIS[{wi_q, 2'd0}];
	assign c1 = BASIS[{wi_q, 2'd1}];
	assign c2 = BASIS[{wi_q, 2'd2}];
	assign c3 = BASIS[{wi_q, 2'd3}];
	assign poly = 52'(c0) * $signed({6'b0, h3_q})
	            + 52'(c1) * $signed({6'b0, h2_q, 15'b0})
	            + 52'(c2) * $signed({6'b0, h_q, 30'b0})
	            + (52'(c3) <<< 45)
	            + 52'sd32768;
	assign w_full = poly >>> 16;

	// Shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_H2: begin
				mul_a = $signed({17'b0, h_q});
				mul_b = $signed({16'b0, h_q});
			end
			ST_H3: begin
				mul_a = prod_q[32:0];
				mul_b = $signed({16'b0, h_q});
			end
			default: begin
				mul_a = w_q;
				mul_b = $signed(v_rd_q[j_q*COMP_W +: COMP_W]);
			end
		endcase
	end

	// Output rounding and saturation.
	always_comb begin
		logic signed [ACC_W-1:0] r;
		out_c = '0;
		for (int j = 0; j < MAX_DIM; j++) begin
			r = (acc_q[j] + (ACC_W'(1) <<< 29)) >>> 30;
			if (VDIM_W'(j) < dim_c) begin
				if (r > $signed(ACC_W'(32'h7FFFFFFF)))
					out_c[j*COMP_W +: COMP_W] = 32'h7FFFFFFF;
				else if (r < -$signed(ACC_W'(33'h080000000)))
					out_c[j*COMP_W +: COMP_W] = 32'h80000000;
				else
					out_c[j*COMP_W +: COMP_W] = r[COMP_W-1:0];
			end
		end
	end

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		t_addr    = i_q;
		v_addr    = kn;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:    if (s_acc && s_tuser == OP_EVAL) state_d = ST_SRCH_A;
			ST_SRCH_A:  state_d = ST_SRCH_C;
			ST_SRCH_C: begin
				if (t_rd_q >= t_q || i_q == cnt_m1)
					state_d = ST_RD_PREV;
				else
					state_d = ST_SRCH_A;
			end
			ST_RD_PREV: begin
				t_addr  = k_q - 1'b1;
				state_d = ST_RD_CUR;
			end
			ST_RD_CUR: begin
				t_addr  = k_q;
				state_d = ST_FRAC;
			end
			ST_FRAC: begin
				div_start = !h_zero;
				state_d = h_zero ? ST_H2 : ST_DIV;
			end
			ST_DIV:     if (div_done) state_d = ST_H2;
			ST_H2:      state_d = ST_H3;
			ST_H3:      state_d = ST_HSAVE;
			ST_HSAVE:   state_d = ST_WGT;
			ST_WGT:     state_d = ST_MUL;
			ST_MUL:     state_d = ST_ACC;
			ST_ACC: begin
				if (j_q == JW'(MAX_DIM - 1))
					state_d = (wi_q == 2'd3) ? ST_OUT : ST_WGT;
				else
					state_d = ST_MUL;
			end
			ST_OUT:     if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				t_q <= t_clamp;
				i_q <= '0;
			end
			ST_SRCH_C: begin
				if (t_rd_q >= t_q || i_q == cnt_m1)
					k_q <= k_pick;
				else
					i_q <= i_q + 1'b1;
			end
			ST_RD_CUR: tprev_q <= t_rd_q;
			ST_FRAC:   h_q <= '0;
			ST_DIV: begin
				if (div_done)
					h_q <= (quo > DIVIDEND_W'(T_ONE)) ? T_ONE : quo[KEY_TIME_W-1:0];
			end
			ST_H3:     h2_q <= prod_q[30:0];
			ST_HSAVE: begin
				h3_q <= prod_q[45:0];
				wi_q <= '0;
				for (int j = 0; j < MAX_DIM; j++)
					acc_q[j] <= '0;
			end
			ST_WGT: begin
				w_q <= w_full[32:0];
				j_q <= '0;
			end
			ST_ACC: begin
				acc_q[j_q] <= acc_q[j_q] + ACC_W'(prod_q);
				if (j_q == JW'(MAX_DIM - 1))
					wi_q <= wi_q + 1'b1;
				else
					j_q <= j_q + 1'b1;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready)
					m_tdata_q <= out_c;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input ready while an evaluation is in progress");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result appeared outside the output step");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_H2) |-> (h_q <= T_ONE))
		else $error("local fraction above one");

	a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished while the sequencer was not waiting");

endmodule
